[design/border_side_primitive_generator_macros.svh]
// Assertion helpers used by border_side_primitive_generator.sv.
`ifndef BORDER_SIDE_PRIMITIVE_GENERATOR_MACROS_SVH
`define BORDER_SIDE_PRIMITIVE_GENERATOR_MACROS_SVH
// Property that must hold whenever the block is out of reset.
`define BSPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked at every edge, reset included.
`define BSPG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[design/bspg_pkg.sv]
package bspg_pkg;
  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [1:0] SIDE_LEFT   = 2'd3;

  localparam logic [3:0] STYLE_DOTTED = 4'd1;
  localparam logic [3:0] STYLE_DASHED = 4'd2;
  localparam logic [3:0] STYLE_DOUBLE = 4'd3;
  localparam logic [3:0] STYLE_GROOVE = 4'd4;
  localparam logic [3:0] STYLE_RIDGE  = 4'd5;
  localparam logic [3:0] STYLE_INSET  = 4'd6;
  localparam logic [3:0] STYLE_OUTSET = 4'd7;
  localparam logic [3:0] STYLE_TRANSP = 4'd8;

  localparam logic [1:0] KIND_RECT   = 2'd0;
  localparam logic [1:0] KIND_POLY   = 2'd1;
  localparam logic [1:0] KIND_DASHED = 2'd2;
  localparam logic [1:0] KIND_DOTTED = 2'd3;

  localparam logic [2:0] SHADE_BASE  = 3'd0;
  localparam logic [2:0] SHADE_DARK  = 3'd1;
  localparam logic [2:0] SHADE_LIGHT = 3'd2;
  localparam logic [2:0] SHADE_DDARK = 3'd3;
  localparam logic [2:0] SHADE_DLIGHT = 3'd4;

  localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [2:0] shade;
    logic       is_rect;
  } prim_ctl_t;
endpackage

[design/bspg_slot.sv]
module bspg_slot
  import bspg_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  prim_ctl_t                    ctl_in,
  input  logic signed [COORD_BITS-1:0] pt_in [8],
  input  logic signed [COORD_BITS-1:0] clip_left,
  input  logic signed [COORD_BITS-1:0] clip_top,
  input  logic signed [COORD_BITS-1:0] clip_right,
  input  logic signed [COORD_BITS-1:0] clip_bottom,
  output prim_ctl_t                    ctl_out,
  output logic signed [COORD_BITS-1:0] pt_out [8]
);
  logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
  logic keep;

  always_comb begin
    x0 = (clip_left > pt_in[0]) ? clip_left : pt_in[0];
    y0 = (clip_top > pt_in[1]) ? clip_top : pt_in[1];
    x1 = (clip_right < pt_in[2]) ? clip_right : pt_in[2];
    y1 = (clip_bottom < pt_in[3]) ? clip_bottom : pt_in[3];
    keep = !ctl_in.is_rect || ((x0 < x1) && (y0 < y1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (adv) begin
      ctl_out.valid <= ctl_in.valid && keep;
    end
    if (adv) begin
      ctl_out.kind <= ctl_in.kind;
      ctl_out.shade <= ctl_in.shade;
      ctl_out.is_rect <= ctl_in.is_rect;
      if (ctl_in.is_rect) begin
        pt_out[0] <= x0;
        pt_out[1] <= y0;
        pt_out[2] <= x1;
        pt_out[3] <= y1;
        for (int i = 4; i < 8; i++) pt_out[i] <= '0;
      end else begin
        for (int i = 0; i < 8; i++) pt_out[i] <= pt_in[i];
      end
    end
  end
endmodule

[design/border_side_primitive_generator.sv]
// Latency: an accepted request passes through stage 1, stage 2 and the clip slots before its first primitive.
// Throughput: one side per cycle when it yields at most one primitive and out_ready is high; a side
// that yields two holds the input until both have left through the single shared result port.
// Reset: synchronous; clears all valid bits and loads the clip box to 0, 0, 32767, 32767.
`include "border_side_primitive_generator_macros.svh"
module border_side_primitive_generator
  import bspg_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] side_code,
  input  logic [3:0] style_code,
  input  logic [9:0] thickness,
  input  logic rectangular,
  input  logic signed [COORD_BITS-1:0] outer_start_x,
  input  logic signed [COORD_BITS-1:0] outer_start_y,
  input  logic signed [COORD_BITS-1:0] inner_start_x,
  input  logic signed [COORD_BITS-1:0] inner_start_y,
  input  logic signed [COORD_BITS-1:0] inner_end_x,
  input  logic signed [COORD_BITS-1:0] inner_end_y,
  input  logic signed [COORD_BITS-1:0] outer_end_x,
  input  logic signed [COORD_BITS-1:0] outer_end_y,
  output logic out_valid,
  input  logic out_ready,
  output logic last_of_run,
  output logic [1:0] prim_kind,
  output logic [2:0] shade,
  output logic signed [COORD_BITS-1:0] pt0_x,
  output logic signed [COORD_BITS-1:0] pt0_y,
  output logic signed [COORD_BITS-1:0] pt1_x,
  output logic signed [COORD_BITS-1:0] pt1_y,
  output logic signed [COORD_BITS-1:0] pt2_x,
  output logic signed [COORD_BITS-1:0] pt2_y,
  output logic signed [COORD_BITS-1:0] pt3_x,
  output logic signed [COORD_BITS-1:0] pt3_y
);
  localparam int W = COORD_BITS;
  localparam int WM = COORD_BITS + 1;
  localparam int WT = COORD_BITS + 3;
  localparam int WP = 2 * WT + 2;
  // Reciprocal of three, scaled by 2**(WT+1), rounded up.
  localparam logic [WT+1:0] RECIP3 = (WT + 2)'(((64'd1 << (WT + 1)) + 64'd2) / 64'd3);

  logic signed [W-1:0] clip_left, clip_top, clip_right, clip_bottom;
  logic adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left <= '0;
      clip_top <= '0;
      clip_right <= W'(32767);
      clip_bottom <= W'(32767);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CLIP_LEFT: clip_left <= cfg_data;
        REG_CLIP_TOP: clip_top <= cfg_data;
        REG_CLIP_RIGHT: clip_right <= cfg_data;
        REG_CLIP_BOTTOM: clip_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [W-1:0] half(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [WM-1:0] s;
    s = WM'(a) + WM'(b);
    half = W'((s + WM'(s[WM-1])) >>> 1);
  endfunction

  function automatic logic signed [WT-1:0] tsum(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    tsum = (WT'(a) <<< 1) + WT'(b);
  endfunction

  // Truncating signed divide by three through a reciprocal multiply.
  function automatic logic signed [W-1:0] div3(input logic signed [WT-1:0] s);
    logic [WT-1:0] m;
    logic [WP-1:0] p;
    logic [WT-1:0] q;
    m = s[WT-1] ? WT'(-s) : WT'(s);
    p = WP'(m) * WP'(RECIP3);
    q = WT'(p >> (WT + 1));
    div3 = s[WT-1] ? W'(-q) : W'(q);
  endfunction

  // Stage 1: register the request and the sums.
  logic v1;
  logic [1:0] s1_side;
  logic [3:0] s1_style;
  logic [9:0] s1_thick;
  logic s1_rect;
  logic signed [W-1:0] p1 [8];
  logic signed [WT-1:0] t1 [8];

  // Stage 2: two primitives composed.
  prim_ctl_t c2a, c2b;
  logic signed [W-1:0] q2a [8], q2b [8];
  prim_ctl_t c2a_next, c2b_next;
  logic signed [W-1:0] q2a_next [8], q2b_next [8];
  logic last2b_only;

  prim_ctl_t c3a, c3b;
  logic signed [W-1:0] q3a [8], q3b [8];

  logic sel;
  logic out_busy;
  logic pop_done;

  always_comb begin
    pop_done = !c3a.valid || !c3b.valid ? 1'b1 : sel;
    out_busy = (c3a.valid || c3b.valid) && !(out_ready && pop_done);
    if (!out_valid) out_busy = 1'b0;
  end

  assign adv = !out_busy && !((c3a.valid && c3b.valid) && !sel && out_valid);
  assign in_ready = adv;

  logic signed [W-1:0] pin [8];
  assign pin = '{outer_start_x, outer_start_y, inner_start_x, inner_start_y,
                 inner_end_x, inner_end_y, outer_end_x, outer_end_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid && style_code != STYLE_TRANSP;
    end
    if (adv) begin
      s1_side <= side_code;
      s1_style <= style_code;
      s1_thick <= thickness;
      s1_rect <= rectangular;
      p1 <= pin;
      t1[0] <= tsum(pin[0], pin[2]);
      t1[1] <= tsum(pin[1], pin[3]);
      t1[2] <= tsum(pin[6], pin[4]);
      t1[3] <= tsum(pin[7], pin[5]);
      t1[4] <= tsum(pin[2], pin[0]);
      t1[5] <= tsum(pin[3], pin[1]);
      t1[6] <= tsum(pin[4], pin[6]);
      t1[7] <= tsum(pin[5], pin[7]);
    end
  end

  always_comb begin
    logic [2:0] sh_in, sh_out;
    logic [1:0] light;
    logic signed [W-1:0] mx, my, ex, ey, xs;
    logic top_right;
    top_right = s1_side == SIDE_TOP || s1_side == SIDE_RIGHT;
    mx = half(p1[0], p1[2]);
    my = half(p1[1], p1[3]);
    ex = half(p1[6], p1[4]);
    ey = half(p1[7], p1[5]);
    if (top_right) begin
      xs = (s1_side == SIDE_TOP && p1[4] != p1[6]) ? p1[4] : p1[6];
    end else begin
      xs = (s1_side == SIDE_LEFT && p1[1] != p1[3]) ? p1[1] : p1[3];
    end
    light = s1_side;
    if (s1_style == STYLE_GROOVE) light = 2'd3 - s1_side;
    if (s1_style == STYLE_INSET) light = s1_side + 2'd2;
    if (s1_style == STYLE_GROOVE || s1_style == STYLE_RIDGE) begin
      sh_in = (light <= 2'd1) ? SHADE_DARK : SHADE_LIGHT;
      sh_out = (light <= 2'd1) ? SHADE_LIGHT : SHADE_DARK;
    end else begin
      case (light)
        2'd0: begin sh_in = SHADE_LIGHT; sh_out = SHADE_DLIGHT; end
        2'd1: begin sh_in = SHADE_DDARK; sh_out = SHADE_DARK; end
        2'd2: begin sh_in = SHADE_DARK; sh_out = SHADE_DDARK; end
        default: begin sh_in = SHADE_DLIGHT; sh_out = SHADE_LIGHT; end
      endcase
    end
    c2a_next = '{valid: v1, kind: KIND_POLY, shade: SHADE_BASE, is_rect: 1'b0};
    c2b_next = '{valid: 1'b0, kind: KIND_POLY, shade: SHADE_BASE, is_rect: 1'b0};
    for (int i = 0; i < 8; i++) begin
      q2a_next[i] = '0;
      q2b_next[i] = '0;
    end
    if (s1_style == STYLE_DOTTED || s1_style == STYLE_DASHED) begin
      c2a_next.kind = (s1_style == STYLE_DOTTED) ? KIND_DOTTED : KIND_DASHED;
      q2a_next[0] = mx;
      q2a_next[1] = my;
      q2a_next[2] = half(p1[4], p1[6]);
      q2a_next[3] = half(p1[5], p1[7]);
    end else if (s1_style == STYLE_DOUBLE) begin
      c2b_next.valid = v1;
      q2a_next = '{p1[0], p1[1], div3(t1[0]), div3(t1[1]),
                   div3(t1[2]), div3(t1[3]), p1[6], p1[7]};
      q2b_next = '{p1[2], p1[3], div3(t1[4]), div3(t1[5]),
                   div3(t1[6]), div3(t1[7]), p1[4], p1[5]};
    end else if (s1_style >= STYLE_GROOVE && s1_style <= STYLE_OUTSET) begin
      if ((s1_rect || s1_thick == 10'd2) && s1_thick != 10'd1) begin
        c2a_next = '{valid: v1, kind: KIND_RECT, shade: sh_in, is_rect: 1'b1};
        c2b_next = '{valid: v1, kind: KIND_RECT, shade: sh_out, is_rect: 1'b1};
        if (top_right) begin
          q2a_next[0] = mx; q2a_next[1] = my; q2a_next[2] = p1[6]; q2a_next[3] = p1[7];
          q2b_next[0] = p1[2]; q2b_next[1] = p1[3]; q2b_next[2] = ex; q2b_next[3] = ey;
        end else begin
          q2a_next[0] = p1[6]; q2a_next[1] = p1[7]; q2a_next[2] = mx; q2a_next[3] = my;
          q2b_next[0] = ex; q2b_next[1] = ey; q2b_next[2] = p1[2]; q2b_next[3] = p1[3];
        end
      end else if (s1_thick == 10'd1) begin
        c2a_next = '{valid: v1, kind: KIND_RECT, shade: top_right ? sh_in : sh_out,
                     is_rect: 1'b1};
        if (top_right) begin
          q2a_next[0] = p1[2]; q2a_next[1] = p1[3]; q2a_next[2] = xs; q2a_next[3] = p1[7];
        end else begin
          q2a_next[0] = p1[6]; q2a_next[1] = p1[7]; q2a_next[2] = p1[2]; q2a_next[3] = xs;
        end
      end else begin
        c2a_next.shade = sh_in;
        c2b_next = '{valid: v1, kind: KIND_POLY, shade: sh_out, is_rect: 1'b0};
        q2a_next = '{p1[0], p1[1], mx, my, ex, ey, p1[6], p1[7]};
        q2b_next = '{p1[2], p1[3], mx, my, ex, ey, p1[4], p1[5]};
      end
    end else begin
      if (s1_rect || s1_thick == 10'd1) begin
        c2a_next = '{valid: v1, kind: KIND_RECT, shade: SHADE_BASE, is_rect: 1'b1};
        if (top_right) begin
          q2a_next[0] = p1[2]; q2a_next[1] = p1[3]; q2a_next[2] = xs; q2a_next[3] = p1[7];
        end else begin
          q2a_next[0] = p1[6]; q2a_next[1] = p1[7]; q2a_next[2] = p1[2]; q2a_next[3] = xs;
        end
      end else begin
        q2a_next = p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2a.valid <= 1'b0;
      c2b.valid <= 1'b0;
    end else if (adv) begin
      c2a <= c2a_next;
      c2b <= c2b_next;
      q2a <= q2a_next;
      q2b <= q2b_next;
    end
  end

  assign last2b_only = 1'b0;

  bspg_slot #(.COORD_BITS(COORD_BITS)) u_slot_a (
    .clk, .rst, .adv, .ctl_in(c2a), .pt_in(q2a),
    .clip_left, .clip_top, .clip_right, .clip_bottom,
    .ctl_out(c3a), .pt_out(q3a)
  );

  bspg_slot #(.COORD_BITS(COORD_BITS)) u_slot_b (
    .clk, .rst, .adv, .ctl_in(c2b), .pt_in(q2b),
    .clip_left, .clip_top, .clip_right, .clip_bottom,
    .ctl_out(c3b), .pt_out(q3b)
  );

  // Output: stage 3 holds one primitive or a pair; sel marks that the first of a pair was already taken.
  logic signed [W-1:0] po [8];
  logic use_b;

  always_comb begin
    use_b = !c3a.valid || sel;
    out_valid = (c3a.valid && !sel) || c3b.valid;
    po = use_b ? q3b : q3a;
    last_of_run = use_b || !c3b.valid;
    prim_kind = use_b ? c3b.kind : c3a.kind;
    shade = use_b ? c3b.shade : c3a.shade;
  end

  assign pt0_x = po[0];
  assign pt0_y = po[1];
  assign pt1_x = po[2];
  assign pt1_y = po[3];
  assign pt2_x = po[4];
  assign pt2_y = po[5];
  assign pt3_x = po[6];
  assign pt3_y = po[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (adv) begin
      sel <= 1'b0;
    end else if (out_valid && out_ready && c3a.valid && c3b.valid && !sel) begin
      sel <= 1'b1;
    end
  end

  `BSPG_ASSERT(a_sel_pair, sel |-> (c3a.valid && c3b.valid), "sel without a pair")
  `BSPG_ASSERT(a_hold, (out_valid && !out_ready) |=> out_valid, "result dropped")
  `BSPG_ASSERT(a_adv_free, (adv && out_valid) |-> (out_ready && last_of_run), "stage overwritten while result waits")
  `BSPG_ASSERT_ALWAYS(a_unused, last2b_only == 1'b0, "unexpected flag")
endmodule

[test/border_side_checker.sv]
`timescale 1ns / 100ps
module border_side_checker
  import bspg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic in_valid,
  input  logic in_ready,
  input  logic [1:0] side_code,
  input  logic [3:0] style_code,
  input  logic [9:0] thickness,
  input  logic rectangular,
  input  logic [7:0][15:0] vtx,
  input  logic out_valid,
  input  logic out_ready,
  input  logic last_of_run,
  input  logic [1:0] prim_kind,
  input  logic [2:0] shade,
  input  logic [7:0][15:0] pts,
  output int errors,
  output int pending
);
  typedef struct packed {
    logic last;
    logic [1:0] kind;
    logic [2:0] shade;
    logic [7:0][15:0] pt;
  } prim_t;

  prim_t prims_due[$];
  longint clip_l, clip_t, clip_r, clip_b;

  function automatic longint sx(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint half(longint a, longint b);
    return (a + b) / 2;
  endfunction

  function automatic longint third(longint a, longint b);
    return (a * 2 + b) / 3;
  endfunction

  function automatic void push_prim(logic [1:0] k, logic [2:0] sh, longint a, longint b,
                                    longint c, longint d, longint e, longint f,
                                    longint g, longint h);
    prim_t p;
    p.last = 1'b0;
    p.kind = k;
    p.shade = sh;
    p.pt[0] = a[15:0]; p.pt[1] = b[15:0]; p.pt[2] = c[15:0]; p.pt[3] = d[15:0];
    p.pt[4] = e[15:0]; p.pt[5] = f[15:0]; p.pt[6] = g[15:0]; p.pt[7] = h[15:0];
    prims_due.push_back(p);
  endfunction

  function automatic void push_rect(logic [2:0] sh, longint x0, longint y0,
                                    longint x1, longint y1);
    if (clip_l > x0) x0 = clip_l;
    if (clip_t > y0) y0 = clip_t;
    if (clip_r < x1) x1 = clip_r;
    if (clip_b < y1) y1 = clip_b;
    if (x0 < x1 && y0 < y1) push_prim(KIND_RECT, sh, x0, y0, x1, y1, 0, 0, 0, 0);
  endfunction

  function automatic void push_single(logic [2:0] sh, logic [1:0] sd, longint p[8]);
    longint e;
    if (sd == SIDE_TOP || sd == SIDE_RIGHT) begin
      e = (sd == SIDE_TOP && p[4] != p[6]) ? p[4] : p[6];
      push_rect(sh, p[2], p[3], e, p[7]);
    end else begin
      e = (sd == SIDE_LEFT && p[1] != p[3]) ? p[1] : p[3];
      push_rect(sh, p[6], p[7], p[2], e);
    end
  endfunction

  function automatic void predict_side();
    longint p[8];
    longint mx, my, ex, ey;
    logic [1:0] lit;
    logic [2:0] sh_in, sh_out;
    int n0;
    n0 = prims_due.size();
    for (int i = 0; i < 8; i++) p[i] = sx(vtx[i]);
    mx = half(p[0], p[2]); my = half(p[1], p[3]);
    ex = half(p[6], p[4]); ey = half(p[7], p[5]);
    if (style_code == STYLE_TRANSP) return;
    if (style_code == STYLE_DOTTED || style_code == STYLE_DASHED) begin
      push_prim(style_code == STYLE_DOTTED ? KIND_DOTTED : KIND_DASHED, SHADE_BASE,
                mx, my, half(p[4], p[6]), half(p[5], p[7]), 0, 0, 0, 0);
    end else if (style_code == STYLE_DOUBLE) begin
      push_prim(KIND_POLY, SHADE_BASE, p[0], p[1], third(p[0], p[2]), third(p[1], p[3]),
                third(p[6], p[4]), third(p[7], p[5]), p[6], p[7]);
      push_prim(KIND_POLY, SHADE_BASE, p[2], p[3], third(p[2], p[0]), third(p[3], p[1]),
                third(p[4], p[6]), third(p[5], p[7]), p[4], p[5]);
    end else if (style_code >= STYLE_GROOVE && style_code <= STYLE_OUTSET) begin
      lit = side_code;
      if (style_code == STYLE_GROOVE || style_code == STYLE_RIDGE) begin
        if (style_code == STYLE_GROOVE) lit = 2'd3 - side_code;
        if (lit <= 2'd1) begin
          sh_in = SHADE_DARK; sh_out = SHADE_LIGHT;
        end else begin
          sh_in = SHADE_LIGHT; sh_out = SHADE_DARK;
        end
      end else begin
        if (style_code == STYLE_INSET) lit = side_code + 2'd2;
        case (lit)
          SIDE_TOP: begin sh_in = SHADE_LIGHT; sh_out = SHADE_DLIGHT; end
          SIDE_RIGHT: begin sh_in = SHADE_DDARK; sh_out = SHADE_DARK; end
          SIDE_BOTTOM: begin sh_in = SHADE_DARK; sh_out = SHADE_DDARK; end
          default: begin sh_in = SHADE_DLIGHT; sh_out = SHADE_LIGHT; end
        endcase
      end
      if ((rectangular || thickness == 10'd2) && thickness != 10'd1) begin
        if (side_code == SIDE_TOP || side_code == SIDE_RIGHT) begin
          push_rect(sh_in, mx, my, p[6], p[7]);
          push_rect(sh_out, p[2], p[3], ex, ey);
        end else begin
          push_rect(sh_in, p[6], p[7], mx, my);
          push_rect(sh_out, ex, ey, p[2], p[3]);
        end
      end else if (thickness == 10'd1) begin
        push_single(side_code <= SIDE_RIGHT ? sh_in : sh_out, side_code, p);
      end else begin
        push_prim(KIND_POLY, sh_in, p[0], p[1], mx, my, ex, ey, p[6], p[7]);
        push_prim(KIND_POLY, sh_out, p[2], p[3], mx, my, ex, ey, p[4], p[5]);
      end
    end else if (rectangular || thickness == 10'd1) begin
      push_single(SHADE_BASE, side_code, p);
    end else begin
      push_prim(KIND_POLY, SHADE_BASE, p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
    end
    if (prims_due.size() > n0) prims_due[prims_due.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_prim();
    prim_t w;
    if (prims_due.size() == 0) begin
      $error("primitive with no request outstanding");
      errors++;
      return;
    end
    w = prims_due.pop_front();
    check_field("last_of_run", w.last, last_of_run);
    check_field("prim_kind", w.kind, prim_kind);
    check_field("shade", w.shade, shade);
    check_field("pt0_x", sx(w.pt[0]), sx(pts[0]));
    check_field("pt0_y", sx(w.pt[1]), sx(pts[1]));
    check_field("pt1_x", sx(w.pt[2]), sx(pts[2]));
    check_field("pt1_y", sx(w.pt[3]), sx(pts[3]));
    check_field("pt2_x", sx(w.pt[4]), sx(pts[4]));
    check_field("pt2_y", sx(w.pt[5]), sx(pts[5]));
    check_field("pt3_x", sx(w.pt[6]), sx(pts[6]));
    check_field("pt3_y", sx(w.pt[7]), sx(pts[7]));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clip_l <= 0; clip_t <= 0; clip_r <= 32767; clip_b <= 32767;
    end else begin
      if (out_valid && out_ready) check_prim();
      if (in_valid && in_ready) predict_side();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CLIP_LEFT: clip_l <= sx(cfg_data);
          REG_CLIP_TOP: clip_t <= sx(cfg_data);
          REG_CLIP_RIGHT: clip_r <= sx(cfg_data);
          default: clip_b <= sx(cfg_data);
        endcase
      end
    end
    pending = prims_due.size();
  end
endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
  import bspg_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = REG_CLIP_LEFT;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  logic [1:0] side_code = SIDE_TOP;
  logic [3:0] style_code = '0;
  logic [9:0] thickness = '0;
  logic rectangular = 1'b0;
  logic [7:0][15:0] vtx = '0;
  logic out_valid, out_ready = 1'b0;
  logic last_of_run;
  logic [1:0] prim_kind;
  logic [2:0] shade;
  logic [7:0][15:0] pts;
  int errors, pending;
  bit burst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  border_side_primitive_generator u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .side_code(side_code), .style_code(style_code), .thickness(thickness),
    .rectangular(rectangular),
    .outer_start_x(vtx[0]), .outer_start_y(vtx[1]),
    .inner_start_x(vtx[2]), .inner_start_y(vtx[3]),
    .inner_end_x(vtx[4]), .inner_end_y(vtx[5]),
    .outer_end_x(vtx[6]), .outer_end_y(vtx[7]),
    .out_valid(out_valid), .out_ready(out_ready), .last_of_run(last_of_run),
    .prim_kind(prim_kind), .shade(shade),
    .pt0_x(pts[0]), .pt0_y(pts[1]), .pt1_x(pts[2]), .pt1_y(pts[3]),
    .pt2_x(pts[4]), .pt2_y(pts[5]), .pt3_x(pts[6]), .pt3_y(pts[7])
  );

  border_side_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .side_code(side_code),
    .style_code(style_code), .thickness(thickness), .rectangular(rectangular), .vtx(vtx),
    .out_valid(out_valid), .out_ready(out_ready), .last_of_run(last_of_run),
    .prim_kind(prim_kind), .shade(shade), .pts(pts),
    .errors(errors), .pending(pending)
  );

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // Outside bursts the receiver may stall at random before each primitive.
  initial begin
    bit taken;
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = burst ? 0 : int'($urandom_range(0, 18));
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        taken = out_valid;
        @(posedge clk);
      end while (!taken);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    bit done;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(negedge clk);
      done = cfg_ready;
      @(posedge clk);
    end while (!done);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_clip(logic [15:0] l, logic [15:0] t, logic [15:0] r, logic [15:0] b);
    drain();
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_RIGHT, r);
    write_reg(REG_CLIP_BOTTOM, b);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_side(logic [1:0] sd, logic [3:0] st, logic [9:0] th, logic rc,
                           logic [7:0][15:0] v);
    bit done;
    side_code <= sd;
    style_code <= st;
    thickness <= th;
    rectangular <= rc;
    vtx <= v;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      done = in_ready;
      @(posedge clk);
    end while (!done);
    if (!burst) begin
      int gap;
      gap = $urandom_range(0, 18);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 400)) - 16'd50;
      2: return $urandom_range(0, 1) ? 16'h8000 + 16'($urandom_range(0, 3))
                                     : 16'h7fff - 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 4000)) - 16'd2000;
    endcase
  endfunction

  // A well-formed side cut from a box with an inner box inset by the thickness.
  function automatic logic [7:0][15:0] box_side(logic [1:0] sd, int th);
    int ox0, oy0, ox1, oy1, ix0, iy0, ix1, iy1;
    logic [7:0][15:0] v;
    ox0 = $urandom_range(0, 600) - 100;
    oy0 = $urandom_range(0, 600) - 100;
    ox1 = ox0 + 2 * th + $urandom_range(0, 300);
    oy1 = oy0 + 2 * th + $urandom_range(0, 300);
    ix0 = ox0 + th; iy0 = oy0 + th; ix1 = ox1 - th; iy1 = oy1 - th;
    case (sd)
      SIDE_TOP: v = {16'(oy0), 16'(ox1), 16'(iy0), 16'(ix1), 16'(iy0), 16'(ix0),
                     16'(oy0), 16'(ox0)};
      SIDE_RIGHT: v = {16'(oy1), 16'(ox1), 16'(iy1), 16'(ix1), 16'(iy0), 16'(ix1),
                       16'(oy0), 16'(ox1)};
      SIDE_BOTTOM: v = {16'(oy1), 16'(ox0), 16'(iy1), 16'(ix0), 16'(iy1), 16'(ix1),
                        16'(oy1), 16'(ox1)};
      default: v = {16'(oy0), 16'(ox0), 16'(iy0), 16'(ix0), 16'(iy1), 16'(ix0),
                    16'(oy1), 16'(ox0)};
    endcase
    return v;
  endfunction

  task automatic random_sides(int count);
    logic [7:0][15:0] v;
    logic [1:0] sd;
    logic [9:0] th;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      sd = 2'($urandom);
      case ($urandom_range(0, 4))
        0: th = 10'd1;
        1: th = 10'd2;
        2: th = 10'($urandom);
        default: th = 10'($urandom_range(0, 12));
      endcase
      if ($urandom_range(0, 9) < 6) begin
        v = box_side(sd, th);
      end else begin
        for (int k = 0; k < 8; k++) v[k] = pick_coord();
      end
      send_side(sd, 4'($urandom_range(0, 9) < 8 ? $urandom_range(0, 8) : $urandom),
                th, 1'($urandom), v);
    end
  endtask

  initial begin
    logic [7:0][15:0] v;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < 8; k++) v[k] = 16'h7fff;
    send_side(SIDE_TOP, 4'd0, 10'h3ff, 1'b1, v);
    for (int k = 0; k < 8; k++) v[k] = 16'h8000;
    send_side(SIDE_LEFT, STYLE_DOUBLE, 10'h3ff, 1'b0, v);
    for (int k = 0; k < 8; k++) v[k] = k[0] ? 16'h8000 : 16'h7fff;
    send_side(SIDE_BOTTOM, STYLE_DASHED, 10'd0, 1'b0, v);
    send_side(SIDE_RIGHT, STYLE_DOTTED, 10'd0, 1'b1, v);
    for (int s = 0; s <= 8; s++) begin
      send_side(2'(s), 4'(s), 10'd5, 1'b0, box_side(2'(s), 5));
    end
    send_side(SIDE_TOP, 4'd12, 10'd3, 1'b1, box_side(SIDE_TOP, 3));
    send_side(SIDE_LEFT, 4'd15, 10'd1, 1'b0, box_side(SIDE_LEFT, 1));
    send_side(SIDE_RIGHT, STYLE_GROOVE, 10'd1, 1'b0, box_side(SIDE_RIGHT, 1));
    send_side(SIDE_BOTTOM, STYLE_RIDGE, 10'd2, 1'b0, box_side(SIDE_BOTTOM, 2));
    send_side(SIDE_LEFT, STYLE_INSET, 10'd4, 1'b1, box_side(SIDE_LEFT, 4));
    send_side(SIDE_TOP, STYLE_OUTSET, 10'd7, 1'b0, box_side(SIDE_TOP, 7));
    v = box_side(SIDE_TOP, 0);
    send_side(SIDE_TOP, 4'd0, 10'd0, 1'b1, v);
    send_side(SIDE_BOTTOM, STYLE_GROOVE, 10'd0, 1'b1, box_side(SIDE_BOTTOM, 0));

    // Hold the sender until every primitive so far has come back.
    drain();
    random_sides(200);

    set_clip(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    random_sides(200);
    set_clip(16'd100, 16'd100, 16'd50, 16'd50);
    send_side(SIDE_TOP, STYLE_RIDGE, 10'd4, 1'b1, box_side(SIDE_TOP, 4));
    random_sides(100);
    set_clip(16'd0, 16'd20, 16'd300, 16'd250);
    random_sides(200);
    set_clip(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_sides(50);
    set_clip(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    random_sides(50);
    set_clip(16'd0, 16'd0, 16'd32767, 16'd32767);
    random_sides(150);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+design
design/bspg_pkg.sv
design/bspg_slot.sv
design/border_side_primitive_generator.sv
test/border_side_checker.sv
test/tb_top.sv
